FILE: hdl/bdq_pkg.sv
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types for the bounded deque with search: operation codes, status
// codes and the sequencer states.
// ----------------------------------------------------------------------------
package bdq_pkg;

  // operation carried by each input item
  typedef enum logic [2:0] {
    KIND_PUSH_TAIL    = 3'd0,
    KIND_POP_HEAD     = 3'd1,
    KIND_POP_TAIL     = 3'd2,
    KIND_REPLACE_HEAD = 3'd3,
    KIND_REPLACE_TAIL = 3'd4,
    KIND_FIND         = 3'd5,
    KIND_COUNT        = 3'd6,
    KIND_CLEAR        = 3'd7
  } kind_t;

  // result status
  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_EMPTY     = 2'd1,
    STATUS_FULL      = 2'd2,
    STATUS_NOT_FOUND = 2'd3
  } status_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_SCAN = 2'd1,
    ST_LAST = 2'd2,
    ST_OUT  = 2'd3
  } state_t;

  // result field widths
  localparam int unsigned POSITION_BITS = 4;
  localparam int unsigned COUNT_BITS    = 5;
  localparam int unsigned LENGTH_BITS   = 5;

endpackage

FILE: hdl/bdq_match.sv
// ----------------------------------------------------------------------------
// bdq_match
// Shared compare unit for the search: one stored word per cycle against the
// key, keeping the first matching offset and the number of matches.
// ----------------------------------------------------------------------------
module bdq_match
  import bdq_pkg::*;
#(
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned AW        = 4,
  parameter int unsigned CW        = 5
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 clr,
  input  logic                 en,
  input  logic [WORD_BITS-1:0] data,
  input  logic [WORD_BITS-1:0] key,
  input  logic [AW-1:0]        pos,
  output logic                 found,
  output logic [AW-1:0]        position,
  output logic [CW-1:0]        count
);

  logic          found_r;
  logic          found_nxt;
  logic [AW-1:0] position_r;
  logic [AW-1:0] position_nxt;
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic          hit;

  // equality compare and accumulate
  always_comb begin
    hit          = en && (data == key);
    found_nxt    = found_r;
    position_nxt = position_r;
    count_nxt    = count_r;
    if (clr) begin
      found_nxt    = 1'b0;
      position_nxt = '0;
      count_nxt    = '0;
    end else if (hit) begin
      count_nxt = count_r + CW'(1);
      if (!found_r) begin
        found_nxt    = 1'b1;
        position_nxt = pos;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r    <= 1'b0;
      position_r <= '0;
      count_r    <= '0;
    end else begin
      found_r    <= found_nxt;
      position_r <= position_nxt;
      count_r    <= count_nxt;
    end
  end

  assign found    = found_r;
  assign position = position_r;
  assign count    = count_r;

  // the first match can never sit at a later offset than the one compared now
  a_pos_order: assert property (@(posedge clk) disable iff (!rst_n)
    (found_r && en && !clr) |-> (position_r < pos))
    else $error("first match offset not below current offset");

  // a hit on an empty tally always records its offset
  a_first_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (hit && !clr && !found_r) |=> (found_r && position_r == $past(pos)))
    else $error("first match not recorded");

  // found and a nonzero tally go together
  a_found_count: assert property (@(posedge clk) disable iff (!rst_n)
    found_r == (count_r != '0))
    else $error("found flag and match tally disagree");

endmodule

FILE: hdl/bounded_deque_with_search.sv
// ----------------------------------------------------------------------------
// bounded_deque_with_search
// Bounded double-ended queue of signed words held in a ring memory, with
// push, pop and replace at either end, find, count and clear.
// ----------------------------------------------------------------------------
// Usage
//   in_*  : one item per operation; in_tuser holds the kind, in_tdata the
//           value (pushed, written by replace, or searched for).
//   out_* : exactly one result item per input item, in order.
// Timing
//   push, pop, replace, clear and searches on an empty queue: result valid
//   on the cycle after the item is taken.
//   find and count: the ring is read one entry per cycle through the single
//   memory read port into a shared compare unit; the result is valid after
//   the scan state, the last compare state and the match register. No new
//   item is taken until the result of the last one has gone.
//   in_tready is high only when the block is idle with no result pending.
// Reset
//   head index and length return to zero; the ring contents are not cleared.
// Back-pressure
//   a result is held on out_* until out_tready; no new item is taken until
//   then.
// ----------------------------------------------------------------------------
module bounded_deque_with_search
  import bdq_pkg::*;
#(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // value[31:0]
  input  logic [2:0]  in_tuser,   // kind[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // found[0], position[4:1], match_count[9:5],
                                  // length[14:10], zero fill[15]
  output logic [1:0]  out_tuser   // status[1:0]
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned OW = $clog2(DEPTH + 1);
  localparam int unsigned SW = AW + 1;
  localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
  localparam logic [OW-1:0] DEPTH_O = OW'(DEPTH);

  // ring memory
  logic [WORD_BITS-1:0] mem [DEPTH];

  state_t               state_r;
  state_t               state_nxt;
  logic [AW-1:0]        head_r;
  logic [AW-1:0]        head_nxt;
  logic [OW-1:0]        occ_r;
  logic [OW-1:0]        occ_nxt;
  status_t              status_r;
  status_t              status_nxt;
  kind_t                op_r;
  logic [WORD_BITS-1:0] key_r;
  logic [AW-1:0]        rd_off_r;
  logic [AW-1:0]        rd_off_nxt;
  logic                 rd_vld_r;
  logic [AW-1:0]        rd_pos_r;
  logic [WORD_BITS-1:0] rd_data_r;

  logic                 in_acc;
  logic                 out_acc;
  kind_t                kind;
  logic [WORD_BITS-1:0] in_word;
  logic                 mem_we;
  logic [AW-1:0]        wr_addr;
  logic [AW-1:0]        rd_addr;
  logic                 scan_rd;
  logic                 scan_last;
  logic [OW-1:0]        occ_dec;

  logic                 m_found;
  logic [AW-1:0]        m_position;
  logic [OW-1:0]        m_count;
  status_t              out_status;
  logic                 res_found;
  logic [AW-1:0]        res_position;
  logic [OW-1:0]        res_count;

  // ring index: base plus offset, wrapped once
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                             input logic [OW-1:0] off);
    logic [SW-1:0] s;
    s = SW'(base) + SW'(off);
    if (s >= DEPTH_S) s = s - DEPTH_S;
    return s[AW-1:0];
  endfunction

  assign in_acc    = in_tvalid && in_tready;
  assign out_acc   = out_tvalid && out_tready;
  assign kind      = kind_t'(in_tuser);
  assign in_word   = WORD_BITS'($signed(in_tdata));
  assign occ_dec   = occ_r - OW'(1);
  assign scan_last = (OW'(rd_off_r) == occ_dec);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if ((kind == KIND_FIND || kind == KIND_COUNT) && occ_r != '0) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_OUT;
          end
        end
      end
      ST_SCAN: begin
        if (scan_last) state_nxt = ST_LAST;
      end
      ST_LAST: state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_tready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    scan_rd    = 1'b0;
    case (state_r)
      ST_IDLE: in_tready  = 1'b1;
      ST_SCAN: scan_rd    = 1'b1;
      ST_LAST: ;
      ST_OUT:  out_tvalid = 1'b1;
      default: ;
    endcase
  end

  // pointer, ring write and status updates for a taken item
  always_comb begin
    head_nxt   = head_r;
    occ_nxt    = occ_r;
    status_nxt = status_r;
    mem_we     = 1'b0;
    wr_addr    = head_r;
    if (in_acc) begin
      status_nxt = STATUS_OK;
      case (kind)
        KIND_PUSH_TAIL: begin
          if (occ_r == DEPTH_O) begin
            status_nxt = STATUS_FULL;
          end else begin
            mem_we  = 1'b1;
            wr_addr = wrap_add(head_r, occ_r);
            occ_nxt = occ_r + OW'(1);
          end
        end
        KIND_POP_HEAD, KIND_POP_TAIL, KIND_REPLACE_HEAD, KIND_REPLACE_TAIL: begin
          if (occ_r == '0) begin
            status_nxt = STATUS_EMPTY;
          end else if (kind == KIND_POP_HEAD) begin
            occ_nxt  = occ_dec;
            head_nxt = (occ_dec == '0) ? '0 : wrap_add(head_r, OW'(1));
          end else if (kind == KIND_POP_TAIL) begin
            occ_nxt  = occ_dec;
            head_nxt = (occ_dec == '0) ? '0 : head_r;
          end else if (kind == KIND_REPLACE_HEAD) begin
            mem_we  = 1'b1;
            wr_addr = head_r;
          end else begin
            mem_we  = 1'b1;
            wr_addr = wrap_add(head_r, occ_dec);
          end
        end
        KIND_FIND, KIND_COUNT: ;
        KIND_CLEAR: begin
          head_nxt = '0;
          occ_nxt  = '0;
        end
        default: ;
      endcase
    end
  end

  // scan offset counter
  always_comb begin
    rd_off_nxt = rd_off_r;
    if (in_acc) begin
      rd_off_nxt = '0;
    end else if (scan_rd) begin
      rd_off_nxt = rd_off_r + AW'(1);
    end
  end

  assign rd_addr = wrap_add(head_r, OW'(rd_off_r));

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      head_r   <= '0;
      occ_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      head_r   <= head_nxt;
      occ_r    <= occ_nxt;
      rd_vld_r <= scan_rd;
    end
  end

  // item payload and scan registers
  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    rd_off_r <= rd_off_nxt;
    rd_pos_r <= rd_off_r;
    if (in_acc) begin
      op_r  <= kind;
      key_r <= in_word;
    end
  end

  // ring memory write and registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= in_word;
    rd_data_r <= mem[rd_addr];
  end

  // shared compare unit
  bdq_match #(
    .WORD_BITS (WORD_BITS),
    .AW        (AW),
    .CW        (OW)
  ) u_match (
    .clk      (clk),
    .rst_n    (rst_n),
    .clr      (in_acc),
    .en       (rd_vld_r),
    .data     (rd_data_r),
    .key      (key_r),
    .pos      (rd_pos_r),
    .found    (m_found),
    .position (m_position),
    .count    (m_count)
  );

  // result item: search fields only for the operation that reports them
  always_comb begin
    out_status   = status_r;
    res_found    = 1'b0;
    res_position = '0;
    res_count    = '0;
    if (op_r == KIND_FIND) begin
      out_status   = m_found ? STATUS_OK : STATUS_NOT_FOUND;
      res_found    = m_found;
      res_position = m_position;
    end
    if (op_r == KIND_COUNT) res_count = m_count;
  end

  assign out_tuser = out_status;
  assign out_tdata = {1'b0,
                      LENGTH_BITS'(occ_r),
                      COUNT_BITS'(res_count),
                      POSITION_BITS'(res_position),
                      res_found};

  // length never exceeds the ring size
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= DEPTH_O)
    else $error("length above ring size");

  // an empty queue always has its head back at the first slot
  a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
    (occ_r == '0) |-> (head_r == '0))
    else $error("head not reset on empty queue");

  // the scan never reads beyond the held entries
  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (OW'(rd_off_r) < occ_r))
    else $error("scan offset outside held entries");

  // a taken item blocks the input until its result has gone
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("input taken while busy");

  // the pointers do not move while a search or a result is pending
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |=> ($stable(occ_r) && $stable(head_r)))
    else $error("pointers changed while busy");

  // a finished result is offered until taken
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid)
    else $error("result dropped under stall");

endmodule
